>>> rtl/core/ttl_session_table_assert.svh
// Assertion macros for the session table RTL
`ifndef TTL_SESSION_TABLE_ASSERT_SVH
`define TTL_SESSION_TABLE_ASSERT_SVH

// same-cycle implication, checked on clk, off during rst
`define TST_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tst assertion failed");

// next-cycle implication, checked on clk, off during rst
`define TST_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tst assertion failed");

`endif

>>> rtl/core/tst_pkg.sv
// Types, codes and helpers shared by the session table RTL
package tst_pkg;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CHECK  = 2'd2,
    KIND_TOUCH  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_BADKEY = 2'd2,
    STAT_UNUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic clr_valid;
    logic wr_exp_en;
    logic wr_key_en;
    logic set_valid;
  } tbl_ctl_t;

  localparam int unsigned KEY_W     = 256;
  localparam int unsigned KEY_CHARS = 32;
  localparam logic [31:0] TTL_RESET = 32'd300000;
  localparam logic [31:0] EXP_MAX   = 32'hFFFF_FFFF;

  localparam logic [7:0] CHAR_DIG_LO = 8'h30;
  localparam logic [7:0] CHAR_DIG_HI = 8'h39;
  localparam logic [7:0] CHAR_LC_LO  = 8'h61;
  localparam logic [7:0] CHAR_LC_HI  = 8'h66;
  localparam logic [7:0] CHAR_UC_LO  = 8'h41;
  localparam logic [7:0] CHAR_UC_HI  = 8'h46;

  function automatic logic char_is_hex(input logic [7:0] c);
    return (c >= CHAR_DIG_LO && c <= CHAR_DIG_HI) ||
           (c >= CHAR_LC_LO && c <= CHAR_LC_HI) ||
           (c >= CHAR_UC_LO && c <= CHAR_UC_HI);
  endfunction

endpackage

>>> rtl/core/tst_req_if.sv
// Request channel: valid/ready plus one request beat
interface tst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_tick;
  logic [63:0] key_chars_0;
  logic [63:0] key_chars_1;
  logic [63:0] key_chars_2;
  logic [63:0] key_chars_3;
  logic [2:0]  slot_in;

  modport source (
    output valid, kind, now_tick, key_chars_0, key_chars_1, key_chars_2, key_chars_3,
           slot_in,
    input  ready
  );

  modport sink (
    input  valid, kind, now_tick, key_chars_0, key_chars_1, key_chars_2, key_chars_3,
           slot_in,
    output ready
  );
endinterface

>>> rtl/core/tst_rsp_if.sv
// Response channel: valid/ready plus one result beat
interface tst_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  slot_out;
  logic [31:0] expiry_out;

  modport source (
    output valid, status, slot_out, expiry_out,
    input  ready
  );

  modport sink (
    input  valid, status, slot_out, expiry_out,
    output ready
  );
endinterface

>>> rtl/core/tst_table.sv
// Slot storage: key and expiry memories with registered read, valid flops
module tst_table #(
  parameter int unsigned SLOTS = 8,
  parameter int unsigned IDX_W = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tst_pkg::tbl_ctl_t         ctl,
  input  logic [IDX_W-1:0]          rd_addr,
  input  logic [IDX_W-1:0]          clr_addr,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [tst_pkg::KEY_W-1:0] wr_key,
  input  logic [31:0]               wr_exp,
  output logic [tst_pkg::KEY_W-1:0] rd_key,
  output logic [31:0]               rd_exp,
  output logic [SLOTS-1:0]          valid
);

  logic [tst_pkg::KEY_W-1:0] key_mem [SLOTS];
  logic [31:0]               exp_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.wr_key_en) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (ctl.wr_exp_en) begin
      exp_mem[wr_addr] <= wr_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_exp <= exp_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.clr_valid) begin
        valid[clr_addr] <= 1'b0;
      end
      if (ctl.set_valid) begin
        valid[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ttl_session_table.sv
// Session table with expiring keys: sequencer, scan datapath and result register
//
// req (sink) carries one request beat: kind, now_tick, a 32-char key, slot_in.
// rsp (source) returns exactly one result beat per request: status, slot_out,
// expiry_out. cfg_we/cfg_wdata load ttl_ticks; write only while idle.
//
// One request at a time. After the request beat: a decode state, then for
// create/lookup/check a scan of all TABLE_SLOTS slots (one slot per cycle
// through the registered memory read and the expiry compares), then a write
// state for create and for touch of a valid slot. Touch and bad keys skip the
// scan. The result is valid from the next cycle on; once rsp takes it, the
// block returns to idle before it accepts the next request.
//
// rst clears all valid bits and loads ttl_ticks with 300000; no sweep needed.
// A stalled rsp holds its beat and keeps req.ready low until it is taken.
module ttl_session_table #(
  parameter int unsigned TABLE_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  tst_req_if.sink     req,
  tst_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  `include "ttl_session_table_assert.svh"

  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_SLOTS + 1);

  tst_pkg::state_t  state, state_next;
  tst_pkg::kind_t   kind_r;
  tst_pkg::status_t res_status;
  tst_pkg::tbl_ctl_t ctl;

  logic [31:0]               ttl_ticks;
  logic [31:0]               now_r;
  logic [tst_pkg::KEY_W-1:0] key_r;
  logic [2:0]                slot_in_r;
  logic [CNT_W-1:0]          issue_cnt;
  logic                      ev_vld;
  logic [IDX_W-1:0]          ev_idx;
  logic                      found;
  logic                      have_free;
  logic [IDX_W-1:0]          pick_idx;
  logic [31:0]               best_exp;
  logic [IDX_W-1:0]          best_idx;
  logic [IDX_W-1:0]          wr_idx;
  logic [2:0]                res_slot;
  logic [31:0]               res_exp;

  logic [tst_pkg::KEY_W-1:0] tbl_key;
  logic [31:0]               tbl_exp;
  logic [TABLE_SLOTS-1:0]    valid_vec;

  logic             scan_issue;
  logic             key_hex;
  logic [6:0]       slot7;
  logic [IDX_W-1:0] touch_idx;
  logic             touch_hit;
  logic             ev_live;
  logic             expired;
  logic             purge;
  logic             hit;
  logic             slot_free;
  logic [31:0]      exp_sum;
  logic [6:0]       ev_slot7;
  logic [6:0]       wr_slot7;

  always_comb begin
    key_hex = 1'b1;
    for (int i = 0; i < tst_pkg::KEY_CHARS; i++) begin
      if (!tst_pkg::char_is_hex(key_r[8*i +: 8])) begin
        key_hex = 1'b0;
      end
    end
  end

  assign slot7     = {4'b0, slot_in_r};
  assign touch_idx = slot7[IDX_W-1:0];
  assign touch_hit = (slot7 < 7'(TABLE_SLOTS)) && valid_vec[touch_idx];

  assign ev_live   = valid_vec[ev_idx];
  assign expired   = tbl_exp <= now_r;
  assign purge     = ev_live && expired && (kind_r != tst_pkg::KIND_CHECK || !found);
  assign hit       = ev_live && !expired && (tbl_key == key_r) && !found &&
                     (kind_r != tst_pkg::KIND_CREATE);
  assign slot_free = !ev_live || expired;
  assign exp_sum   = now_r + ttl_ticks;
  assign ev_slot7  = 7'(ev_idx);
  assign wr_slot7  = 7'(wr_idx);

  always_comb begin
    state_next = state;
    ctl        = '0;
    scan_issue = 1'b0;
    unique case (state)
      tst_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = tst_pkg::ST_START;
        end
      end
      tst_pkg::ST_START: begin
        priority if (kind_r == tst_pkg::KIND_LOOKUP && !key_hex) begin
          state_next = tst_pkg::ST_DONE;
        end else if (kind_r == tst_pkg::KIND_TOUCH) begin
          state_next = touch_hit ? tst_pkg::ST_WRITE : tst_pkg::ST_DONE;
        end else begin
          state_next = tst_pkg::ST_SCAN;
        end
      end
      tst_pkg::ST_SCAN: begin
        scan_issue    = issue_cnt != CNT_W'(TABLE_SLOTS);
        ctl.rd_en     = scan_issue;
        ctl.clr_valid = ev_vld && purge;
        if (!scan_issue && !ev_vld) begin
          state_next = (kind_r == tst_pkg::KIND_CREATE) ? tst_pkg::ST_WRITE
                                                         : tst_pkg::ST_DONE;
        end
      end
      tst_pkg::ST_WRITE: begin
        ctl.wr_exp_en = 1'b1;
        ctl.wr_key_en = kind_r == tst_pkg::KIND_CREATE;
        ctl.set_valid = kind_r == tst_pkg::KIND_CREATE;
        state_next    = tst_pkg::ST_DONE;
      end
      tst_pkg::ST_DONE: begin
        if (rsp.ready) begin
          state_next = tst_pkg::ST_IDLE;
        end
      end
      default: state_next = tst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tst_pkg::ST_IDLE;
      ttl_ticks <= tst_pkg::TTL_RESET;
      ev_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      ev_vld <= scan_issue;
      if (cfg_we) begin
        ttl_ticks <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tst_pkg::ST_IDLE && req.valid) begin
      kind_r    <= tst_pkg::kind_t'(req.kind);
      now_r     <= req.now_tick;
      key_r     <= {req.key_chars_3, req.key_chars_2, req.key_chars_1, req.key_chars_0};
      slot_in_r <= req.slot_in;
    end

    if (state == tst_pkg::ST_START) begin
      issue_cnt <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
      pick_idx  <= '0;
      best_exp  <= tst_pkg::EXP_MAX;
      best_idx  <= '0;
      wr_idx    <= touch_idx;
      res_slot  <= 3'd0;
      res_exp   <= 32'd0;
      priority if (kind_r == tst_pkg::KIND_LOOKUP && !key_hex) begin
        res_status <= tst_pkg::STAT_BADKEY;
      end else if (kind_r == tst_pkg::KIND_TOUCH) begin
        res_status <= tst_pkg::STAT_UNUSED;
      end else begin
        res_status <= tst_pkg::STAT_MISS;
      end
    end

    if (scan_issue) begin
      issue_cnt <= CNT_W'(issue_cnt + 1'b1);
      ev_idx    <= issue_cnt[IDX_W-1:0];
    end

    if (ev_vld && kind_r == tst_pkg::KIND_CREATE) begin
      if (slot_free && !have_free) begin
        have_free <= 1'b1;
        pick_idx  <= ev_idx;
      end
      if (tbl_exp < best_exp) begin
        best_exp <= tbl_exp;
        best_idx <= ev_idx;
      end
    end

    if (ev_vld && hit) begin
      found      <= 1'b1;
      res_status <= tst_pkg::STAT_OK;
      res_slot   <= ev_slot7[2:0];
      res_exp    <= tbl_exp;
    end

    if (state == tst_pkg::ST_SCAN && state_next == tst_pkg::ST_WRITE) begin
      wr_idx <= have_free ? pick_idx : best_idx;
    end

    if (state == tst_pkg::ST_WRITE) begin
      res_status <= tst_pkg::STAT_OK;
      res_slot   <= wr_slot7[2:0];
      res_exp    <= exp_sum;
    end
  end

  tst_table #(
    .SLOTS (TABLE_SLOTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_addr  (issue_cnt[IDX_W-1:0]),
    .clr_addr (ev_idx),
    .wr_addr  (wr_idx),
    .wr_key   (key_r),
    .wr_exp   (exp_sum),
    .rd_key   (tbl_key),
    .rd_exp   (tbl_exp),
    .valid    (valid_vec)
  );

  assign req.ready      = state == tst_pkg::ST_IDLE;
  assign rsp.valid      = state == tst_pkg::ST_DONE;
  assign rsp.status     = res_status;
  assign rsp.slot_out   = res_slot;
  assign rsp.expiry_out = res_exp;

  `TST_ASSERT_IMPL(a_busy_while_result, rsp.valid, !req.ready)
  `TST_ASSERT_NEXT(a_accept_starts, req.valid && req.ready, state == tst_pkg::ST_START)
  `TST_ASSERT_IMPL(a_fail_zero, rsp.valid && res_status != tst_pkg::STAT_OK, {res_slot, res_exp} == '0)
  `TST_ASSERT_IMPL(a_scan_bound, state == tst_pkg::ST_SCAN, issue_cnt <= CNT_W'(TABLE_SLOTS))

endmodule

>>> test/tb_top.sv
// Testbench for ttl_session_table: random and directed requests checked against a table model
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [8*22-1:0] HEX_SET = "0123456789abcdefABCDEF";
  localparam logic [47:0] EDGE_HEX = "09afAF";
  localparam logic [47:0] EDGE_BAD = {"/:@G", 8'h60, "g"};

  typedef struct {
    tst_pkg::kind_t kind;
    logic [31:0]    now;
    logic [255:0]   key;
    logic [2:0]     slot;
  } sess_req_t;

  typedef struct {
    tst_pkg::status_t status;
    logic [2:0]       slot;
    logic [31:0]      expiry;
  } sess_rsp_t;

  function automatic bit is_hex_char(logic [7:0] c);
    return tst_pkg::char_is_hex(c);
  endfunction

  function automatic bit key_all_hex(logic [255:0] k);
    for (int i = 0; i < 32; i++) begin
      if (!is_hex_char(k[8*i +: 8])) return 1'b0;
    end
    return 1'b1;
  endfunction

  class session_scoreboard;
    bit           live [SLOTS];
    logic [255:0] keys [SLOTS];
    logic [31:0]  expiry [SLOTS];
    logic [31:0]  ttl;
    sess_rsp_t    pending_rsp [$];
    int           errors;

    function new();
      ttl = tst_pkg::TTL_RESET;
      errors = 0;
      foreach (live[i]) begin
        live[i] = 1'b0;
        keys[i] = '0;
        expiry[i] = '0;
      end
    endfunction

    function void drop_expired(logic [31:0] now);
      for (int i = 0; i < SLOTS; i++) begin
        if (live[i] && expiry[i] <= now) live[i] = 1'b0;
      end
    endfunction

    function void note_request(sess_req_t r);
      sess_rsp_t   e;
      int          pick;
      logic [31:0] best;
      bit          hit;
      e.status = tst_pkg::STAT_MISS;
      e.slot = '0;
      e.expiry = '0;
      pick = -1;
      hit = 1'b0;
      case (r.kind)
        tst_pkg::KIND_CREATE: begin
          drop_expired(r.now);
          for (int i = 0; i < SLOTS; i++) begin
            if (!live[i] && pick < 0) pick = i;
          end
          if (pick < 0) begin
            best = tst_pkg::EXP_MAX;
            pick = 0;
            for (int i = 0; i < SLOTS; i++) begin
              if (expiry[i] < best) begin
                best = expiry[i];
                pick = i;
              end
            end
          end
          live[pick] = 1'b1;
          keys[pick] = r.key;
          expiry[pick] = r.now + ttl;
          e.status = tst_pkg::STAT_OK;
          e.slot = 3'(pick);
          e.expiry = expiry[pick];
        end
        tst_pkg::KIND_LOOKUP: begin
          if (!key_all_hex(r.key)) begin
            e.status = tst_pkg::STAT_BADKEY;
          end else begin
            drop_expired(r.now);
            for (int i = 0; i < SLOTS; i++) begin
              if (!hit && live[i] && keys[i] == r.key) begin
                hit = 1'b1;
                e.status = tst_pkg::STAT_OK;
                e.slot = 3'(i);
                e.expiry = expiry[i];
              end
            end
          end
        end
        tst_pkg::KIND_CHECK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit && live[i]) begin
              if (expiry[i] <= r.now) begin
                live[i] = 1'b0;
              end else if (keys[i] == r.key) begin
                hit = 1'b1;
                e.status = tst_pkg::STAT_OK;
                e.slot = 3'(i);
                e.expiry = expiry[i];
              end
            end
          end
        end
        default: begin
          if (live[r.slot]) begin
            expiry[r.slot] = r.now + ttl;
            e.status = tst_pkg::STAT_OK;
            e.slot = r.slot;
            e.expiry = expiry[r.slot];
          end else begin
            e.status = tst_pkg::STAT_UNUSED;
          end
        end
      endcase
      pending_rsp.push_back(e);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(logic [1:0] st, logic [2:0] sl, logic [31:0] ex);
      sess_rsp_t e;
      if (pending_rsp.size() == 0) begin
        report($sformatf("result beat with none pending: status %0d slot %0d expiry %h",
                         st, sl, ex));
        return;
      end
      e = pending_rsp.pop_front();
      if (st !== e.status) report($sformatf("status %0d, want %0d", st, e.status));
      if (sl !== e.slot) report($sformatf("slot_out %0d, want %0d", sl, e.slot));
      if (ex !== e.expiry) report($sformatf("expiry_out %h, want %h", ex, e.expiry));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  tst_req_if req_if ();
  tst_rsp_if rsp_if ();

  ttl_session_table #(
    .TABLE_SLOTS(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  session_scoreboard sb = new();
  bit          quiet_run = 1'b0;
  int          hold_req = 0;
  int unsigned cycles = 0;
  logic [255:0] key_pool [12];
  logic [31:0] now_t;
  int unsigned step_max;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_result(rsp_if.status, rsp_if.slot_out, rsp_if.expiry_out);
  end

  // response side: random short stalls, plus a long hold-off on request
  initial begin : rsp_side
    int hold_left;
    hold_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left == 0 && !quiet_run && $urandom_range(0, 99) < 6)
        hold_left = 1;
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  function automatic logic [255:0] hex_key();
    logic [255:0] k;
    int idx;
    for (int i = 0; i < 32; i++) begin
      idx = $urandom_range(0, 21);
      k[8*i +: 8] = HEX_SET[8*(21-idx) +: 8];
    end
    return k;
  endfunction

  function automatic logic [255:0] noise_key();
    logic [255:0] k;
    for (int w = 0; w < 8; w++) k[32*w +: 32] = $urandom;
    return k;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    c = 8'($urandom);
    while (is_hex_char(c)) c = 8'($urandom);
    return c;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(tst_pkg::kind_t k, logic [31:0] now, logic [255:0] key,
                           logic [2:0] slot);
    sess_req_t r;
    int gap;
    r.kind = k;
    r.now = now;
    r.key = key;
    r.slot = slot;
    if (!quiet_run && $urandom_range(0, 99) < 6) begin
      gap = $urandom_range(1, 16);
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.kind = k;
    req_if.now_tick = now;
    req_if.key_chars_0 = key[63:0];
    req_if.key_chars_1 = key[127:64];
    req_if.key_chars_2 = key[191:128];
    req_if.key_chars_3 = key[255:192];
    req_if.slot_in = slot;
    req_if.valid = 1'b1;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    req_if.valid = 1'b0;
    while (sb.pending_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ttl(logic [31:0] v);
    drain_and_settle();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.ttl = v;
  endtask

  initial begin : stim
    logic [255:0]   key_a, key_b, key_c, key_mix, k;
    logic [31:0]    ttl_list [8];
    tst_pkg::kind_t kd;
    int             p;
    int             pos;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_if.valid = 1'b0;
    req_if.kind = tst_pkg::KIND_CREATE;
    req_if.now_tick = '0;
    req_if.key_chars_0 = '0;
    req_if.key_chars_1 = '0;
    req_if.key_chars_2 = '0;
    req_if.key_chars_3 = '0;
    req_if.slot_in = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    key_a = hex_key();
    key_b = hex_key();
    key_c = hex_key();
    for (int i = 0; i < 32; i++) key_mix[8*i +: 8] = EDGE_HEX[8*(5-(i%6)) +: 8];

    send_item(tst_pkg::KIND_LOOKUP, 32'd10, key_a, 3'd0);
    send_item(tst_pkg::KIND_CHECK, 32'd10, key_a, 3'd0);
    send_item(tst_pkg::KIND_TOUCH, 32'd10, key_a, 3'd0);
    send_item(tst_pkg::KIND_TOUCH, 32'd10, key_a, 3'd7);
    send_item(tst_pkg::KIND_CREATE, 32'd100, key_a, 3'd0);
    send_item(tst_pkg::KIND_CREATE, 32'd100, key_b, 3'd0);
    send_item(tst_pkg::KIND_CREATE, 32'd101, key_a, 3'd0);
    send_item(tst_pkg::KIND_LOOKUP, 32'd102, key_a, 3'd0);
    send_item(tst_pkg::KIND_CHECK, 32'd102, key_a, 3'd0);
    send_item(tst_pkg::KIND_TOUCH, 32'd200, key_b, 3'd1);
    // characters just outside each hex range
    for (int i = 0; i < 6; i++) begin
      k = key_a;
      k[8*(5*i+1) +: 8] = EDGE_BAD[8*(5-i) +: 8];
      send_item(tst_pkg::KIND_LOOKUP, 32'd210, k, 3'd0);
    end
    send_item(tst_pkg::KIND_CREATE, 32'd300, {32{8'hFF}}, 3'd0);
    send_item(tst_pkg::KIND_CHECK, 32'd300, {32{8'hFF}}, 3'd0);
    send_item(tst_pkg::KIND_CREATE, 32'd300, key_mix, 3'd0);
    send_item(tst_pkg::KIND_LOOKUP, 32'd301, key_mix, 3'd0);
    send_item(tst_pkg::KIND_CREATE, 32'd300100, key_c, 3'd0);
    send_item(tst_pkg::KIND_LOOKUP, 32'd300101, key_a, 3'd0);
    send_item(tst_pkg::KIND_TOUCH, 32'd400000, key_a, 3'd1);
    send_item(tst_pkg::KIND_CREATE, 32'hFFFF_FFF0, key_b, 3'd0);
    send_item(tst_pkg::KIND_CHECK, 32'hFFFF_FFF0, key_b, 3'd0);

    ttl_list = '{32'd0, tst_pkg::EXP_MAX, 32'd1, 32'($urandom_range(20, 400)),
                 tst_pkg::TTL_RESET, 32'($urandom), 32'd1000, 32'h7FFF_FFFF};
    now_t = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      write_ttl(ttl_list[ph]);
      if (ttl_list[ph] == 0) step_max = 50;
      else if (ttl_list[ph] > 32'h1000_0000) step_max = $urandom_range(1, 1000);
      else step_max = ttl_list[ph] / $urandom_range(6, 48) + 1;
      for (int j = 0; j < 12; j++)
        key_pool[j] = ($urandom_range(0, 99) < 20) ? noise_key() : hex_key();
      quiet_run = (ph == 4);
      for (int n = 0; n < 210; n++) begin
        if (ph == 2 && n == 100) hold_req = 400;
        if (ph == 6 && n == 105) drain_and_settle();
        p = $urandom_range(0, 99);
        if (p < 35) kd = tst_pkg::KIND_CREATE;
        else if (p < 60) kd = tst_pkg::KIND_LOOKUP;
        else if (p < 80) kd = tst_pkg::KIND_CHECK;
        else kd = tst_pkg::KIND_TOUCH;
        p = $urandom_range(0, 99);
        if (p < 80) k = key_pool[$urandom_range(0, 11)];
        else if (p < 90) k = hex_key();
        else k = noise_key();
        if (kd == tst_pkg::KIND_LOOKUP && $urandom_range(0, 99) < 8) begin
          pos = $urandom_range(0, 31);
          k[8*pos +: 8] = non_hex_char();
        end
        p = $urandom_range(0, 99);
        if (p < 10) now_t = now_t;
        else if (p < 88) now_t = now_t + 32'($urandom_range(0, step_max));
        else if (p < 94) now_t = $urandom;
        else now_t = now_t - 32'($urandom_range(0, step_max));
        send_item(kd, now_t, k, 3'($urandom_range(0, 7)));
      end
    end
    quiet_run = 1'b0;

    drain_and_settle();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
